### rtl/core/rpsm_pkg.sv
package rpsm_pkg;

    typedef enum logic
    {
        OP_PULSE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t         op;
        logic [31:0] now_ms;
        logic [9:0]  gps_speed_kmh;
        logic [7:0]  gps_fix_age;
    } item_t;

    typedef struct packed
    {
        logic [9:0] reported_speed;
        logic [8:0] wheel_speed;
        logic       from_gps;
        logic       timed_out;
    } res_t;

    localparam logic REG_CIRC     = 1'b0;
    localparam logic REG_TAKEOVER = 1'b1;

    localparam logic [8:0] CIRC_RESET     = 9'd196;
    localparam logic [8:0] TAKEOVER_RESET = 9'd80;

    localparam logic [31:0] WINDOW_MS   = 32'd250;
    localparam logic [31:0] TIMEOUT_MS  = 32'd1000;
    localparam logic [31:0] DEBOUNCE_MS = 32'd15;
    localparam logic [4:0]  PEAK_MAX    = 5'd31;
    localparam logic [7:0]  FIX_AGE_MAX = 8'd2;

    localparam int DIV_W = 33;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);
    localparam logic [DIV_W-1:0] SPEED_LIMIT = DIV_W'(299);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

### rtl/core/reed_pulse_speed_meter_unit.sv
// Path: a queue entry, then the back end's result register, then the output register;
// a pulse that closes a window also passes MULT, START, WAIT and the 33-step restoring
// divider. The back end takes a new item only after the last result has left EMIT.
// A 2-item queue sits in front; the output register accepts when empty or not stalled.
// Reset (rst_n low, asynchronous): queue empty, window start and last count 0,
// peak count 1, wheel speed 0, circumference 196 cm, takeover 80 km/h.
module reed_pulse_speed_meter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] now_ms,
    input  logic [9:0]  gps_speed_kmh,
    input  logic [7:0]  gps_fix_age,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  reported_speed,
    output logic [8:0]  wheel_speed,
    output logic        from_gps,
    output logic        timed_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [8:0]      circ_reg;
    logic [8:0]      takeover_reg;
    logic            q_valid;
    rpsm_pkg::item_t q_item;
    logic            q_pop;
    logic            res_valid;
    rpsm_pkg::res_t  res;
    logic            res_ready;
    logic            out_valid_reg;
    rpsm_pkg::res_t  out_reg;

    assign cfg_ready      = 1'b1;
    assign res_ready      = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign reported_speed = out_reg.reported_speed;
    assign wheel_speed    = out_reg.wheel_speed;
    assign from_gps       = out_reg.from_gps;
    assign timed_out      = out_reg.timed_out;

    rpsm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .now_ms        (now_ms),
        .gps_speed_kmh (gps_speed_kmh),
        .gps_fix_age   (gps_fix_age),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    rpsm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .circ      (circ_reg),
        .takeover  (takeover_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg     <= rpsm_pkg::CIRC_RESET;
            takeover_reg <= rpsm_pkg::TAKEOVER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpsm_pkg::REG_CIRC:     circ_reg     <= cfg_data;
                rpsm_pkg::REG_TAKEOVER: takeover_reg <= cfg_data;
                default:                circ_reg     <= circ_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    a_gps_not_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(from_gps && timed_out))
        else $error("gps result flagged as timeout");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> (reported_speed == '0 && wheel_speed == '0))
        else $error("timeout item with non-zero speed");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wheel_speed < 9'd299))
        else $error("stored wheel speed out of range");

    a_gps_above: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && from_gps) |-> (reported_speed > {1'b0, takeover_reg}))
        else $error("gps speed reported below takeover");

endmodule

### rtl/core/rpsm_front.sv
module rpsm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [31:0]          now_ms,
    input  logic [9:0]           gps_speed_kmh,
    input  logic [7:0]           gps_fix_age,
    output logic                 q_valid,
    output rpsm_pkg::item_t      q_item,
    input  logic                 q_pop
);

    rpsm_pkg::item_t                   entry_reg [rpsm_pkg::QUEUE_DEPTH];
    logic [rpsm_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [rpsm_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [rpsm_pkg::QCNT_W-1:0]       count_reg;
    logic                              push;
    logic                              pop;
    rpsm_pkg::item_t                   new_item;

    assign in_stall = (count_reg == rpsm_pkg::QCNT_W'(rpsm_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op            = rpsm_pkg::op_t'(mode);
        new_item.now_ms        = now_ms;
        new_item.gps_speed_kmh = gps_speed_kmh;
        new_item.gps_fix_age   = gps_fix_age;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/rpsm_div.sv
module rpsm_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpsm_pkg::DIV_W-1:0]  num,
    input  logic [rpsm_pkg::DIV_W-1:0]  den,
    output logic                        done,
    output logic [rpsm_pkg::DIV_W-1:0]  quot
);

    logic [rpsm_pkg::DIV_W-1:0] rem_reg;
    logic [rpsm_pkg::DIV_W-1:0] quo_reg;
    logic [rpsm_pkg::DIV_W-1:0] den_reg;
    logic [rpsm_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rpsm_pkg::DIV_W:0]   rem_shift;
    logic                       ge;
    logic [rpsm_pkg::DIV_W:0]   trial;

    // restoring division, one quotient bit a cycle
    assign rem_shift = {rem_reg, quo_reg[rpsm_pkg::DIV_W-1]};
    assign ge        = (rem_shift >= {1'b0, den_reg});
    assign trial     = ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    assign done      = done_reg;
    assign quot      = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[rpsm_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[rpsm_pkg::DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= rpsm_pkg::DIV_STEPS;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rpsm_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/rpsm_back.sv
module rpsm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [8:0]          circ,
    input  logic [8:0]          takeover,
    input  logic                q_valid,
    input  rpsm_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                res_valid,
    output rpsm_pkg::res_t      res,
    input  logic                res_ready
);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_MULT  = 5'b00010,
        ST_START = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    window_start_reg, window_start_next;
    logic [31:0]    last_counted_reg, last_counted_next;
    logic [4:0]     peak_reg, peak_next;
    logic [8:0]     speed_reg, speed_next;
    logic [31:0]    now_reg, now_next;
    logic [31:0]    elapsed_reg, elapsed_next;
    logic [19:0]    prod_reg, prod_next;
    rpsm_pkg::res_t res_reg, res_next;

    logic [31:0]    elapsed;
    logic [31:0]    since_count;
    logic [13:0]    cp;
    logic           div_start;
    logic           div_done;
    logic [rpsm_pkg::DIV_W-1:0] div_num;
    logic [rpsm_pkg::DIV_W-1:0] div_den;
    logic [rpsm_pkg::DIV_W-1:0] div_quot;

    assign elapsed     = q_item.now_ms - window_start_reg;
    assign since_count = q_item.now_ms - last_counted_reg;
    assign cp          = {5'b0, circ} * {9'b0, peak_reg};
    // rounded C*P*36/e as floor((2*C*P*36 + e) / (2*e))
    assign div_num     = {12'b0, prod_reg, 1'b0} + {1'b0, elapsed_reg};
    assign div_den     = {elapsed_reg, 1'b0};
    assign div_start   = (state_reg == ST_START);
    assign res_valid   = (state_reg == ST_EMIT);
    assign res         = res_reg;

    rpsm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next        = state_reg;
        window_start_next = window_start_reg;
        last_counted_next = last_counted_reg;
        peak_next         = peak_reg;
        speed_next        = speed_reg;
        now_next          = now_reg;
        elapsed_next      = elapsed_reg;
        prod_next         = prod_reg;
        res_next          = res_reg;
        q_pop             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop                  = 1'b1;
                    res_next.reported_speed = '0;
                    res_next.from_gps       = 1'b0;
                    res_next.timed_out      = 1'b0;
                    res_next.wheel_speed    = speed_reg;
                    state_next              = ST_EMIT;
                    case (q_item.op)
                        rpsm_pkg::OP_QUERY:
                        begin
                            if (elapsed < rpsm_pkg::TIMEOUT_MS)
                            begin
                                if ((speed_reg > takeover)
                                    && (q_item.gps_speed_kmh > {1'b0, takeover})
                                    && (q_item.gps_fix_age <= rpsm_pkg::FIX_AGE_MAX))
                                begin
                                    res_next.reported_speed = q_item.gps_speed_kmh;
                                    res_next.from_gps       = 1'b1;
                                end
                                else
                                begin
                                    res_next.reported_speed = {1'b0, speed_reg};
                                end
                            end
                            else
                            begin
                                speed_next           = '0;
                                res_next.wheel_speed = '0;
                                res_next.timed_out   = 1'b1;
                            end
                        end
                        rpsm_pkg::OP_PULSE:
                        begin
                            if (elapsed > rpsm_pkg::WINDOW_MS)
                            begin
                                now_next     = q_item.now_ms;
                                elapsed_next = elapsed;
                                state_next   = ST_MULT;
                            end
                            else if (since_count > rpsm_pkg::DEBOUNCE_MS)
                            begin
                                if (peak_reg < rpsm_pkg::PEAK_MAX)
                                begin
                                    peak_next = peak_reg + 1'b1;
                                end
                                last_counted_next = q_item.now_ms;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_MULT:
            begin
                prod_next  = {1'b0, cp, 5'b0} + {4'b0, cp, 2'b0};
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quot < rpsm_pkg::SPEED_LIMIT)
                    begin
                        speed_next           = div_quot[8:0];
                        res_next.wheel_speed = div_quot[8:0];
                    end
                    window_start_next = now_reg;
                    last_counted_next = now_reg;
                    peak_next         = 5'd1;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_start_reg <= '0;
            last_counted_reg <= '0;
            peak_reg         <= 5'd1;
            speed_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            window_start_reg <= window_start_next;
            last_counted_reg <= last_counted_next;
            peak_reg         <= peak_next;
            speed_reg        <= speed_next;
        end
    end

endmodule

### tb/tb_reed_pulse_speed_meter_unit.sv
module tb_reed_pulse_speed_meter_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASE_ITEMS    = 125;
    localparam logic [63:0] KMH_FACTOR = 64'd36;
    localparam logic [63:0] SPEED_CEIL = 64'd299;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       mode = 1'b0;
    logic [31:0] now_ms = '0;
    logic [9:0] gps_speed_kmh = '0;
    logic [7:0] gps_fix_age = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [9:0] reported_speed;
    logic [8:0] wheel_speed;
    logic       from_gps;
    logic       timed_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = rpsm_pkg::REG_CIRC;
    logic [8:0] cfg_data = '0;

    reed_pulse_speed_meter_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .now_ms         (now_ms),
        .gps_speed_kmh  (gps_speed_kmh),
        .gps_fix_age    (gps_fix_age),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reported_speed (reported_speed),
        .wheel_speed    (wheel_speed),
        .from_gps       (from_gps),
        .timed_out      (timed_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // meter state as the block should hold it
    logic [8:0]  circ_cfg = rpsm_pkg::CIRC_RESET;
    logic [8:0]  takeover_cfg = rpsm_pkg::TAKEOVER_RESET;
    logic [31:0] win_start = '0;
    logic [31:0] last_count = '0;
    logic [4:0]  peaks = 5'd1;
    logic [8:0]  wheel = '0;

    rpsm_pkg::item_t items_to_send[$];
    rpsm_pkg::res_t  readings_due[$];

    int tx_idle_max = 3;
    int rx_idle_max = 3;
    int tx_gap = 0;
    int rx_gap = 0;
    int bad_results = 0;
    int quiet_cycles = 0;
    logic [31:0] stamp = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rpsm_pkg::res_t next_speed_reading(input rpsm_pkg::item_t it);
        logic [31:0] since_win;
        logic [31:0] since_count;
        logic [63:0] num;
        logic [63:0] spd;
        rpsm_pkg::res_t r;
        r = '0;
        since_win = it.now_ms - win_start;
        since_count = it.now_ms - last_count;
        if (it.op == rpsm_pkg::OP_PULSE)
        begin
            if (since_win > rpsm_pkg::WINDOW_MS)
            begin
                num = 64'(circ_cfg) * 64'(peaks) * KMH_FACTOR;
                spd = (64'd2 * num + 64'(since_win)) / (64'd2 * 64'(since_win));
                if (spd < SPEED_CEIL)
                    wheel = spd[8:0];
                win_start = it.now_ms;
                last_count = it.now_ms;
                peaks = 5'd1;
            end
            else if (since_count > rpsm_pkg::DEBOUNCE_MS)
            begin
                if (peaks < rpsm_pkg::PEAK_MAX)
                    peaks = peaks + 5'd1;
                last_count = it.now_ms;
            end
        end
        else
        begin
            if (since_win < rpsm_pkg::TIMEOUT_MS)
            begin
                if (wheel > takeover_cfg && it.gps_speed_kmh > 10'(takeover_cfg)
                    && it.gps_fix_age <= rpsm_pkg::FIX_AGE_MAX)
                begin
                    r.reported_speed = it.gps_speed_kmh;
                    r.from_gps = 1'b1;
                end
                else
                begin
                    r.reported_speed = 10'(wheel);
                end
            end
            else
            begin
                wheel = '0;
                r.timed_out = 1'b1;
            end
        end
        r.wheel_speed = wheel;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                readings_due.push_back(next_speed_reading(
                    rpsm_pkg::item_t'{rpsm_pkg::op_t'(mode), now_ms, gps_speed_kmh,
                                      gps_fix_age}));
                tx_gap = $urandom_range(0, tx_idle_max);
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap == 0 && items_to_send.size() != 0)
                begin
                    rpsm_pkg::item_t nxt;
                    nxt = items_to_send.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.op;
                    now_ms <= nxt.now_ms;
                    gps_speed_kmh <= nxt.gps_speed_kmh;
                    gps_fix_age <= nxt.gps_fix_age;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (tx_gap != 0)
                        tx_gap--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                rpsm_pkg::res_t got;
                rpsm_pkg::res_t want;
                got = '{reported_speed, wheel_speed, from_gps, timed_out};
                if (readings_due.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected item: rep=%0d wheel=%0d gps=%0b tout=%0b",
                                 got.reported_speed, got.wheel_speed, got.from_gps,
                                 got.timed_out);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.reported_speed !== want.reported_speed
                        || got.wheel_speed !== want.wheel_speed
                        || got.from_gps !== want.from_gps
                        || got.timed_out !== want.timed_out)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("mismatch: want rep=%0d wheel=%0d gps=%0b tout=%0b, %s",
                                     want.reported_speed, want.wheel_speed, want.from_gps,
                                     want.timed_out,
                                     $sformatf("got rep=%0d wheel=%0d gps=%0b tout=%0b",
                                               got.reported_speed, got.wheel_speed,
                                               got.from_gps, got.timed_out));
                    end
                end
                rx_gap = $urandom_range(0, rx_idle_max);
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
            end
            out_stall <= (rx_gap != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [8:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rpsm_pkg::REG_CIRC)
            circ_cfg = val;
        else
            takeover_cfg = val;
        @(posedge clk);
    endtask

    // sampled away from the rising edge so the driver and monitor have settled
    task automatic drain();
        while (items_to_send.size() != 0 || in_valid || readings_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_item(input rpsm_pkg::op_t op, input logic [31:0] t,
                            input logic [9:0] gps, input logic [7:0] age);
        items_to_send.push_back(rpsm_pkg::item_t'{op, t, gps, age});
    endtask

    // mostly pulse trains at a steady cadence with queries in between,
    // plus bounce, long silences and the odd random item
    task automatic queue_random(input int count, input logic [8:0] takeover);
        int r;
        int cadence;
        rpsm_pkg::item_t it;
        cadence = $urandom_range(16, 150);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (k % 20 == 0)
                cadence = $urandom_range(16, 150);
            it.op = rpsm_pkg::OP_PULSE;
            it.gps_speed_kmh = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 3) == 0)
                it.gps_fix_age = 8'($urandom_range(0, 255));
            else
                it.gps_fix_age = 8'($urandom_range(0, 3));
            if (r < 55)
            begin
                stamp = stamp + 32'($urandom_range(cadence - 6, cadence + 6));
            end
            else if (r < 80)
            begin
                it.op = rpsm_pkg::OP_QUERY;
                stamp = stamp + 32'($urandom_range(0, 30));
                if (r < 70)
                    it.gps_speed_kmh = 10'(takeover) + 10'($urandom_range(0, 2)) - 10'd1;
            end
            else if (r < 88)
            begin
                stamp = stamp + 32'($urandom_range(0, 16));
            end
            else if (r < 94)
            begin
                stamp = stamp + 32'($urandom_range(900, 1100));
                if (r % 2 == 1)
                    it.op = rpsm_pkg::OP_QUERY;
            end
            else
            begin
                stamp = $urandom();
                it.op = rpsm_pkg::op_t'($urandom_range(0, 1));
            end
            it.now_ms = stamp;
            items_to_send.push_back(it);
        end
    endtask

    task automatic run_phase(input logic [8:0] circ, input logic [8:0] takeover,
                             input int tx_max, input int rx_max, input bit near_wrap);
        write_reg(rpsm_pkg::REG_CIRC, circ);
        write_reg(rpsm_pkg::REG_TAKEOVER, takeover);
        @(negedge clk);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        if (near_wrap)
            stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
        queue_random(PHASE_ITEMS, takeover);
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_item(rpsm_pkg::OP_QUERY, 32'd0, 10'd0, 8'd0);
        add_item(rpsm_pkg::OP_PULSE, 32'd10, 10'd0, 8'd0);
        add_item(rpsm_pkg::OP_PULSE, 32'd16, 10'd0, 8'd0);
        add_item(rpsm_pkg::OP_PULSE, 32'd31, 10'd0, 8'd0);     // exactly at the debounce edge
        add_item(rpsm_pkg::OP_PULSE, 32'd32, 10'd0, 8'd0);
        add_item(rpsm_pkg::OP_PULSE, 32'd250, 10'd0, 8'd0);    // window edge, still counts
        add_item(rpsm_pkg::OP_PULSE, 32'd251, 10'd0, 8'd0);    // closes window
        add_item(rpsm_pkg::OP_QUERY, 32'd300, 10'd1023, 8'd2);
        add_item(rpsm_pkg::OP_QUERY, 32'd301, 10'd81, 8'd3);
        add_item(rpsm_pkg::OP_QUERY, 32'd1250, 10'd255, 8'd255);
        add_item(rpsm_pkg::OP_QUERY, 32'd1251, 10'd1023, 8'd0); // timeout
        add_item(rpsm_pkg::OP_PULSE, 32'hFFFF_FFF0, 10'd1023, 8'd255);
        add_item(rpsm_pkg::OP_PULSE, 32'd5, 10'd0, 8'd0);       // across the wrap
        for (int k = 0; k < 10; k++)
            add_item(rpsm_pkg::OP_PULSE, 32'(21 + 16 * k), 10'd0, 8'd0);
        add_item(rpsm_pkg::OP_PULSE, 32'd235, 10'd0, 8'd0);     // speed too high, kept old
        add_item(rpsm_pkg::OP_QUERY, 32'd236, 10'd500, 8'd1);
        drain();

        stamp = 32'd1000;
        run_phase(rpsm_pkg::CIRC_RESET, rpsm_pkg::TAKEOVER_RESET, 11, 11, 1'b0);
        run_phase(9'd50, 9'd0, 0, 0, 1'b0);
        run_phase(9'd300, 9'd298, 11, 0, 1'b0);
        run_phase(9'd0, 9'd511, 0, 11, 1'b1);
        run_phase(9'd511, 9'd150, 11, 11, 1'b0);
        run_phase(9'($urandom_range(50, 300)), 9'($urandom_range(0, 298)), 11, 11, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_results == 0 && readings_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/rpsm_pkg.sv
rtl/core/rpsm_front.sv
rtl/core/rpsm_div.sv
rtl/core/rpsm_back.sv
rtl/core/reed_pulse_speed_meter_unit.sv
tb/tb_reed_pulse_speed_meter_unit.sv
